@@ hdl/shabs_pkg.sv @@
// shared types, constants and round functions of the sha-256 byte stream hash
package shabs_pkg;

	localparam int unsigned WordW    = 32;
	localparam int unsigned ChainN   = 8;
	localparam int unsigned BlockN   = 16;
	localparam int unsigned RoundN   = 64;
	localparam int unsigned CountW   = 61;
	localparam logic [7:0]  PadByte  = 8'h80;
	localparam logic [3:0]  LenHiIdx = 4'd14;
	localparam logic [3:0]  LastIdx  = 4'd15;
	localparam logic [5:0]  LastRnd  = 6'd63;
	localparam logic [2:0]  LastSel  = 3'd7;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} out_item_t;

	// controls from the sequencer to the datapath
	typedef struct packed {
		logic       push;
		word_t      word;
		logic       load;
		logic       step;
		logic [5:0] rnd;
		logic       fold;
		logic       reinit;
		logic [2:0] sel;
	} ctl_t;

	localparam word_t InitHash [ChainN] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [RoundN] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t bsig0(word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t ssig1(word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

@@ hdl/shabs_chan_if.sv @@
// valid/ready channel carrying one word of a given payload type
interface shabs_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/sha256_byte_stream_hash.sv @@
// sha-256 over a byte stream: input words of bytes or finish, output digest words
// Usage:
//   in  channel: mode 0 absorbs data_byte, mode 1 ends the message.
//   out channel: eight digest words, H0 first; last_word marks the eighth.
// Sequencing:
//   a data byte is taken in the idle state; the byte that completes a 64-byte
//   block starts the rounds and then a chaining add, during which no byte is
//   taken. All rounds run through one round unit, one round per cycle.
//   finish: padding words are shifted in one per cycle, up to 16 per block,
//   over one or two compressed blocks, then the eight words are offered.
// The in channel is not ready while a block is compressed, during finish and
// while digest words are offered; in and out are never active together.
// When the receiver stalls, the current digest word holds until taken.
// After the eighth word is taken the chaining words return to the initial
// hash values and the block is ready for a new message.
// Reset: arst_n clears control state and chain words at once; ready right after.
module sha256_byte_stream_hash (
	input  logic         clk,
	input  logic         arst_n,
	shabs_chan_if.sink   in,
	shabs_chan_if.source out
);
	import shabs_pkg::*;

	ctl_t ctl;

	shabs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.in_ready  (in.ready),
		.mode      (in.data.mode),
		.data_byte (in.data.data_byte),
		.out_valid (out.valid),
		.out_ready (out.ready),
		.last_word (out.data.last_word),
		.ctl       (ctl)
	);

	shabs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.digest_word (out.data.digest_word)
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in.ready && out.valid))
		else $error("input ready while digest words pending");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready && in.data.mode |=> !in.ready)
		else $error("ready right after finish");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.ready && out.data.last_word |=> in.ready && !out.valid)
		else $error("not idle after last digest word");
`endif
endmodule

@@ hdl/shabs_ctrl.sv @@
// sequencer: byte packing, padding, round counting and digest readout
module shabs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            mode,
	input  logic [7:0]      data_byte,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            last_word,
	output shabs_pkg::ctl_t ctl
);
	import shabs_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [23:0]         partial_q;
	logic [1:0]          bcnt_q;
	logic [3:0]          wcnt_q;
	logic [CountW-1:0]   count_q;
	logic [63:0]         bitlen_q;
	logic [5:0]          rnd_q;
	logic [2:0]          sel_q;
	logic                pad_q, len_q, last_q, fin_q;
	logic                in_acc, out_acc;
	word_t               pad_word;

	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign last_word = (sel_q == LastSel);

	// first padding word: held bytes, then 0x80, then zeros
	always_comb begin
		case (bcnt_q)
			2'd0:    pad_word = {PadByte, 24'd0};
			2'd1:    pad_word = {partial_q[7:0], PadByte, 16'd0};
			2'd2:    pad_word = {partial_q[15:0], PadByte, 8'd0};
			default: pad_word = {partial_q, PadByte};
		endcase
	end

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		ctl.rnd    = rnd_q;
		ctl.sel    = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && !mode && bcnt_q == 2'd3) begin
					ctl.push = 1'b1;
					ctl.word = {partial_q, data_byte};
					if (wcnt_q == LastIdx) begin
						ctl.load = 1'b1;
						state_d  = ST_ROUND;
					end
				end else if (in_acc && mode) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				ctl.push = 1'b1;
				if (pad_q)
					ctl.word = pad_word;
				else if (wcnt_q == LenHiIdx)
					ctl.word = bitlen_q[63:32];
				else if (wcnt_q == LastIdx && len_q)
					ctl.word = bitlen_q[31:0];
				else
					ctl.word = '0;
				if (wcnt_q == LastIdx) begin
					ctl.load = 1'b1;
					state_d  = ST_ROUND;
				end
			end
			ST_ROUND: begin
				ctl.step = 1'b1;
				if (rnd_q == LastRnd)
					state_d = ST_FOLD;
			end
			ST_FOLD: begin
				ctl.fold = 1'b1;
				if (last_q)
					state_d = ST_EMIT;
				else if (fin_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (out_acc && sel_q == LastSel) begin
					ctl.reinit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			partial_q <= '0;
			bcnt_q    <= '0;
			wcnt_q    <= '0;
			count_q   <= '0;
			bitlen_q  <= '0;
			rnd_q     <= '0;
			sel_q     <= '0;
			pad_q     <= 1'b0;
			len_q     <= 1'b0;
			last_q    <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.push)
				wcnt_q <= wcnt_q + 4'd1;
			if (in_acc && !mode) begin
				count_q <= count_q + {{(CountW-1){1'b0}}, 1'b1};
				if (bcnt_q == 2'd3) begin
					partial_q <= '0;
					bcnt_q    <= '0;
				end else begin
					partial_q <= {partial_q[15:0], data_byte};
					bcnt_q    <= bcnt_q + 2'd1;
				end
			end
			if (in_acc && mode) begin
				bitlen_q <= {count_q, 3'b000};
				count_q  <= '0;
				pad_q    <= 1'b1;
				fin_q    <= 1'b1;
			end
			if (state_q == ST_PAD) begin
				if (pad_q) begin
					pad_q     <= 1'b0;
					partial_q <= '0;
					bcnt_q    <= '0;
				end else if (wcnt_q == LenHiIdx) begin
					len_q <= 1'b1;
				end else if (wcnt_q == LastIdx && len_q) begin
					last_q <= 1'b1;
				end
			end
			if (ctl.step)
				rnd_q <= rnd_q + 6'd1;
			if (out_acc)
				sel_q <= sel_q + 3'd1;
			if (ctl.reinit) begin
				fin_q  <= 1'b0;
				len_q  <= 1'b0;
				last_q <= 1'b0;
			end
		end
	end
endmodule

@@ hdl/shabs_datapath.sv @@
// message window, working variables, shared round unit and chaining words
module shabs_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  shabs_pkg::ctl_t    ctl,
	output logic [31:0]        digest_word
);
	import shabs_pkg::*;

	word_t win_q [BlockN];
	word_t var_q [ChainN];
	word_t chain_q [ChainN];
	word_t w_next, t1, t2, ch, maj;

	// schedule expansion off the sliding window
	assign w_next = win_q[0] + ssig0(win_q[1]) + win_q[9] + ssig1(win_q[14]);

	assign ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
	assign maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	assign t1  = var_q[7] + bsig1(var_q[4]) + ch + RoundK[ctl.rnd] + win_q[0];
	assign t2  = bsig0(var_q[0]) + maj;

	assign digest_word = chain_q[ctl.sel];

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.step) begin
			for (int i = 0; i < BlockN - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[BlockN-1] <= ctl.push ? ctl.word : w_next;
		end
		if (ctl.load) begin
			for (int i = 0; i < ChainN; i++)
				var_q[i] <= chain_q[i];
		end else if (ctl.step) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ChainN; i++)
				chain_q[i] <= InitHash[i];
		end else if (ctl.reinit) begin
			for (int i = 0; i < ChainN; i++)
				chain_q[i] <= InitHash[i];
		end else if (ctl.fold) begin
			for (int i = 0; i < ChainN; i++)
				chain_q[i] <= chain_q[i] + var_q[i];
		end
	end
endmodule
